// ----- src/wl512_pkg.sv -----
package wl512_pkg;

	localparam int WORD_W     = 32;
	localparam int IDX_W      = 4;
	localparam int POOL_DEPTH = 16;
	localparam int NUM_TAPS   = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef enum logic {
		OP_GEN  = 1'b0,
		OP_LOAD = 1'b1
	} op_t;

	localparam word_t TEMPER_MASK = 32'hDA44_2D24;

	// tap order: current word, far tap, near tap, previous word
	localparam int TAP_CUR  = 0;
	localparam int TAP_FAR  = 1;
	localparam int TAP_NEAR = 2;
	localparam int TAP_PREV = 3;

	localparam idx_t OFS_PREV = 4'd15;
	localparam idx_t TAP_OFS [NUM_TAPS] = '{4'd0, 4'd13, 4'd9, OFS_PREV};

	typedef struct packed {
		word_t cur;
		word_t far;
		word_t near;
		word_t prev;
	} tap_t;

	typedef struct packed {
		word_t first_word;
		word_t second_word;
	} mix_out_t;

endpackage

// ----- src/wl512_mix.sv -----
module wl512_mix import wl512_pkg::*; (
	input  tap_t     taps,
	output mix_out_t res
);

	word_t b;
	word_t c;
	word_t n1;
	word_t d;

	always_comb begin
		b  = taps.cur ^ taps.far ^ (taps.cur << 16) ^ (taps.far << 15);
		c  = taps.near ^ (taps.near >> 11);
		n1 = b ^ c;
		// tempering term uses the freshly written word
		d  = n1 ^ ((n1 << 5) & TEMPER_MASK);
		res.first_word  = n1;
		res.second_word = taps.prev ^ b ^ d ^ (taps.prev << 2) ^ (b << 18) ^ (c << 28);
	end

endmodule

// ----- src/well512_random_generator.sv -----
// channel  | direction | handshake             | payload
// cmd      | in        | cmd_valid / cmd_stall | op, word_index, seed_word
// rnd      | out       | rnd_valid / rnd_stall | random_word
//
// one beat per cycle while cmd_stall is low; a generate result goes through stage 1 and
// the result register before it shows on rnd. a load that finds an unwritten-back word
// at another index stalls cmd while the pool memory's single write port writes it back.
// after reset the pool reads as zero through per-entry valid bits; no clearing pass.
// rnd_stall holds the result register; cmd_stall rises only when that register is full
// and stalled with stage 1 full, or while such a load sits in stage 1.
module well512_random_generator import wl512_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_stall,
	input  logic  op,
	input  idx_t  word_index,
	input  word_t seed_word,
	output logic  rnd_valid,
	input  logic  rnd_stall,
	output word_t random_word
);

	word_t mem_a [POOL_DEPTH];
	word_t mem_b [POOL_DEPTH];
	logic [POOL_DEPTH-1:0] wr_done_q;

	idx_t ptr_q;
	idx_t raddr [NUM_TAPS];

	logic  vld_s1;
	logic  op_s1;
	idx_t  p_s1;
	idx_t  widx_s1;
	word_t seed_s1;
	word_t rd_s1 [NUM_TAPS];
	logic  [NUM_TAPS-1:0] ok_s1;
	logic  [NUM_TAPS-1:0] fwd_s1;
	word_t fwd_data_s1;

	logic  pend_vld_q;
	idx_t  pend_idx_q;
	word_t pend_q;
	logic  flush_q;

	logic  rnd_valid_q;
	word_t random_word_q;

	logic  accept;
	logic  is_load_s1;
	logic  out_free;
	logic  s1_go;
	logic  load_flush;
	logic  we;
	idx_t  waddr;
	word_t wdata;
	word_t tap_w [NUM_TAPS];
	tap_t  taps;
	mix_out_t mix;

	assign is_load_s1 = (op_s1 == OP_LOAD);
	assign out_free   = !rnd_valid_q || !rnd_stall;
	assign s1_go      = vld_s1 && (is_load_s1 || out_free);
	// a load leaves a live pending word elsewhere: write it back next cycle
	assign load_flush = vld_s1 && is_load_s1 && pend_vld_q && (pend_idx_q != widx_s1);
	assign cmd_stall  = (vld_s1 && !s1_go) || load_flush;
	assign accept     = cmd_valid && !cmd_stall;

	assign rnd_valid   = rnd_valid_q;
	assign random_word = random_word_q;

	always_comb begin
		for (int i = 0; i < NUM_TAPS; i++) begin
			raddr[i] = ptr_q + TAP_OFS[i];
		end
	end

	// single write port, shared by write-back, load and generate
	always_comb begin
		we    = 1'b0;
		waddr = pend_idx_q;
		wdata = pend_q;
		if (flush_q) begin
			we = 1'b1;
		end else if (s1_go) begin
			we = 1'b1;
			if (is_load_s1) begin
				waddr = widx_s1;
				wdata = seed_s1;
			end else begin
				waddr = p_s1;
				wdata = mix.first_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_a[waddr] <= wdata;
			mem_b[waddr] <= wdata;
		end
		if (accept) begin
			rd_s1[TAP_CUR]  <= mem_a[raddr[TAP_CUR]];
			rd_s1[TAP_FAR]  <= mem_a[raddr[TAP_FAR]];
			rd_s1[TAP_NEAR] <= mem_b[raddr[TAP_NEAR]];
			rd_s1[TAP_PREV] <= mem_b[raddr[TAP_PREV]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_done_q <= '0;
		end else if (we) begin
			wr_done_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			p_s1        <= ptr_q;
			widx_s1     <= word_index;
			seed_s1     <= seed_word;
			fwd_data_s1 <= wdata;
			for (int i = 0; i < NUM_TAPS; i++) begin
				ok_s1[i]  <= wr_done_q[raddr[i]];
				fwd_s1[i] <= we && (waddr == raddr[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ptr_q  <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
				ptr_q  <= (op == OP_LOAD) ? '0 : ptr_q + OFS_PREV;
			end else if (s1_go) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// newest value wins: pending word, then the write seen at read time, then memory; unwritten entries read as zero
	always_comb begin
		idx_t a;
		for (int i = 0; i < NUM_TAPS; i++) begin
			a = p_s1 + TAP_OFS[i];
			if (pend_vld_q && (pend_idx_q == a)) begin
				tap_w[i] = pend_q;
			end else if (fwd_s1[i]) begin
				tap_w[i] = fwd_data_s1;
			end else if (ok_s1[i]) begin
				tap_w[i] = rd_s1[i];
			end else begin
				tap_w[i] = '0;
			end
		end
		taps.cur  = tap_w[TAP_CUR];
		taps.far  = tap_w[TAP_FAR];
		taps.near = tap_w[TAP_NEAR];
		taps.prev = tap_w[TAP_PREV];
	end

	wl512_mix u_mix (
		.taps (taps),
		.res  (mix)
	);

	// second word of a step stays in a register; the next step overwrites its entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			pend_idx_q <= '0;
			flush_q    <= 1'b0;
		end else begin
			flush_q <= load_flush;
			if (flush_q) begin
				pend_vld_q <= 1'b0;
			end else if (s1_go && !is_load_s1) begin
				pend_vld_q <= 1'b1;
				pend_idx_q <= p_s1 + OFS_PREV;
			end else if (s1_go && is_load_s1 && (pend_idx_q == widx_s1)) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && !is_load_s1) begin
			pend_q        <= mix.second_word;
			random_word_q <= mix.second_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_valid_q <= 1'b0;
		end else if (s1_go && !is_load_s1) begin
			rnd_valid_q <= 1'b1;
		end else if (!rnd_stall) begin
			rnd_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/wl512_checker.sv -----
module wl512_checker import wl512_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  cmd_valid,
	input logic  cmd_stall,
	input logic  op,
	input logic  rnd_valid,
	input logic  rnd_stall,
	input word_t random_word
);

	logic seeded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
		end else if (cmd_valid && !cmd_stall && (op == OP_LOAD)) begin
			seeded_q <= 1'b1;
		end
	end

	a_rnd_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_valid && rnd_stall |=> rnd_valid)
		else $error("result beat dropped while stalled");

	a_rnd_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_valid && rnd_stall |=> $stable(random_word))
		else $error("stalled result word changed");

	// an unseeded pool only ever yields zero words
	a_zero_pool: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_valid && !seeded_q |-> random_word == '0)
		else $error("nonzero word from unseeded pool");

	// without output backpressure the only input stall is the single write-back cycle
	a_stall_short: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall && !rnd_stall |=> !cmd_stall)
		else $error("input stalled longer than one cycle without output stall");

endmodule

bind well512_random_generator wl512_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_stall   (cmd_stall),
	.op          (op),
	.rnd_valid   (rnd_valid),
	.rnd_stall   (rnd_stall),
	.random_word (random_word)
);
